// File: rtl/lmsp_pkg.sv
// Package for the linear move step planner: shared types, codes and constants.
// Used by lmsp_alu and linear_move_step_planner_unit; depends on nothing else.
`default_nettype none

package lmsp_pkg;

  localparam int unsigned NumAxes  = 4;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CountW   = 6;
  localparam int unsigned ResW     = 65;
  localparam int unsigned RateNumW = 49;
  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 264;

  // Reset values of the configuration registers.
  localparam logic [31:0] StepLenReset = 32'd655;
  localparam logic [31:0] XyMaxReset   = 32'd196608000;
  localparam logic [31:0] ZeMaxReset   = 32'd39321600;

  // Iteration counts of the shared unit.
  localparam logic [CountW-1:0] LenStepDiv = 6'd32;
  localparam logic [CountW-1:0] LenWideDiv = 6'd49;
  localparam logic [CountW-1:0] LenMul     = 6'd32;
  localparam logic [CountW-1:0] LenSqrt    = 6'd32;

  // Configuration register indexes.
  localparam logic [2:0] CfgXStep = 3'd0;
  localparam logic [2:0] CfgYStep = 3'd1;
  localparam logic [2:0] CfgZStep = 3'd2;
  localparam logic [2:0] CfgEStep = 3'd3;
  localparam logic [2:0] CfgXMax  = 3'd4;
  localparam logic [2:0] CfgYMax  = 3'd5;
  localparam logic [2:0] CfgZMax  = 3'd6;
  localparam logic [2:0] CfgEMax  = 3'd7;

  // Motion mode codes.
  localparam logic [1:0] ModeRapid  = 2'd0;
  localparam logic [1:0] ModeLinear = 2'd1;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_SQRT,
    OP_MUL
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SQR,
    ST_ROOT,
    ST_COS,
    ST_FEED,
    ST_RATE,
    ST_FINISH
  } plan_state_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [CountW-1:0] len;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

`default_nettype wire

// File: rtl/lmsp_alu.sv
// Shared iterative arithmetic unit: restoring divide, square root and
// saturating shift-add multiply, one bit of result per cycle. Uses lmsp_pkg.
`default_nettype none

module lmsp_alu (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lmsp_pkg::alu_req_t           req_i,
  input  wire logic [63:0]                  opx_i,   // dividend, radicand or multiplier, MSB aligned
  input  wire logic [63:0]                  opd_i,   // divisor or multiplicand
  output lmsp_pkg::alu_rsp_t                rsp_o,
  output logic [lmsp_pkg::ResW-1:0]         res_o
);

  logic                          busy_q, done_q;
  lmsp_pkg::alu_op_e             op_q;
  logic [lmsp_pkg::CountW-1:0]   cnt_q;
  logic [63:0]                   x_q, d_q;
  logic [40:0]                   rem_q;
  logic [lmsp_pkg::ResW-1:0]     res_q;

  logic [40:0] div_sh, div_dv, sq_sh, sq_trial;
  logic        div_ge, sq_ge;
  logic [66:0] mul_sum;

  // One iteration of each operation.
  always_comb begin
    div_sh   = {rem_q[39:0], x_q[63]};
    div_dv   = {1'b0, d_q[39:0]};
    div_ge   = (div_sh >= div_dv);
    sq_sh    = {rem_q[38:0], x_q[63:62]};
    sq_trial = {5'b0, res_q[33:0], 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    mul_sum  = {1'b0, res_q, 1'b0} + {3'b0, (x_q[63] ? d_q : 64'd0)};
  end

  // Control: a request loads the operands and runs len iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= lmsp_pkg::OP_DIV;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= req_i.len - 6'd1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= opx_i;
      d_q   <= opd_i;
      rem_q <= '0;
      res_q <= '0;
    end else if (busy_q) begin
      case (op_q)
        lmsp_pkg::OP_DIV: begin
          x_q   <= {x_q[62:0], 1'b0};
          rem_q <= div_ge ? (div_sh - div_dv) : div_sh;
          res_q <= {res_q[63:0], div_ge};
        end
        lmsp_pkg::OP_SQRT: begin
          x_q   <= {x_q[61:0], 2'b00};
          rem_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
          res_q <= {res_q[63:0], sq_ge};
        end
        lmsp_pkg::OP_MUL: begin
          x_q   <= {x_q[62:0], 1'b0};
          // Saturate at 2^64, far above any clamp limit.
          res_q <= (mul_sum[66:64] != 3'd0) ? {1'b1, 64'd0} : mul_sum[64:0];
        end
        default: begin
          res_q <= res_q;
        end
      endcase
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = res_q;

endmodule

`default_nettype wire

// File: rtl/linear_move_step_planner_unit.sv
// A rejected move goes from idle to the finish state, then to the output register;
// a rapid move passes the step and rate states, a linear move also the square,
// root, cosine and feed states, worked by the shared bit-serial divide, square-root
// and multiply unit (lmsp_alu), one result bit per cycle. One move at a time; ready
// only when the sequencer is idle. Reset (asynchronous, active low) restores the
// configuration defaults and clears positions, feed and output valid.
`default_nettype none

module linear_move_step_planner_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [2:0]                      cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: axis_mask, x_target, y_target, z_target, e_target, feed_present,
  //        feed_value, arc_words_present, zero fill
  input  wire logic [lmsp_pkg::InDataW-1:0]    s_axis_tdata_i,
  // tuser: motion_mode, absolute_mode
  input  wire logic [2:0]                      s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // tdata: moving_axes, x/y/z/e_steps, x/y/z/e_rate, zero fill
  output logic [lmsp_pkg::OutDataW-1:0]        m_axis_tdata_o,
  // tuser: move_valid
  output logic                                 m_axis_tuser_o
);

  lmsp_pkg::plan_state_e state_q, state_d;

  logic [3:0][31:0] step_len_q, vmax_q;
  logic [3:0][31:0] pos_mm_q, pos_st_q, tgt_q, dst_q, rate_q;
  logic [3:0][48:0] n_q;
  logic [31:0]      feed_q, dist_q;
  logic [63:0]      sum_q;
  logic [3:0]       mask_q;
  logic [1:0]       mode_q, ax_q;
  logic             ok_q, issued_q;
  logic             out_valid_q, out_user_q;
  logic [lmsp_pkg::OutDataW-1:0] out_data_q, out_data_d;

  lmsp_pkg::alu_req_t req;
  lmsp_pkg::alu_rsp_t rsp;
  logic [lmsp_pkg::ResW-1:0] res;
  logic [63:0] opx, opd;

  logic in_fire, ok_now, adv, last_ax, out_free;
  logic [3:0][32:0] a_sh;
  logic [32:0] dmm, a_abs;
  logic        shr;
  logic [31:0] s_len, t_cur, abs_t, pos_cur, step_sat;
  logic [37:0] div60;
  logic [33:0] q_sgn;
  logic [34:0] diff;
  logic [48:0] lim, n_cur, n_sel;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == lmsp_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign ok_now          = !s_axis_tuser_i[1] && s_axis_tuser_i[2] &&
                           (s_axis_tdata_i[3:0] != 4'd0) && !s_axis_tdata_i[165];
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Path lengths per axis from the latched targets.
  always_comb begin
    shr = 1'b0;
    for (int i = 0; i < lmsp_pkg::NumAxes; i++) begin
      dmm   = {tgt_q[i][31], tgt_q[i]} - {pos_mm_q[i][31], pos_mm_q[i]};
      a_abs = dmm[32] ? (33'd0 - dmm) : dmm;
      a_sh[i] = mask_q[i] ? a_abs : 33'd0;
      if (i < 3 && a_sh[i][32:31] != 2'b00) begin
        shr = 1'b1;
      end
    end
    for (int i = 0; i < lmsp_pkg::NumAxes; i++) begin
      a_sh[i] = shr ? {1'b0, a_sh[i][32:1]} : a_sh[i];
    end
  end

  // Values of the axis under work.
  always_comb begin
    s_len   = (step_len_q[ax_q] == 32'd0) ? 32'd1 : step_len_q[ax_q];
    t_cur   = tgt_q[ax_q];
    pos_cur = pos_st_q[ax_q];
    abs_t   = t_cur[31] ? (32'd0 - t_cur) : t_cur;
    div60   = ({6'd0, s_len} << 6) - ({6'd0, s_len} << 2);
    q_sgn   = t_cur[31] ? (34'd0 - {2'b00, res[31:0]}) : {2'b00, res[31:0]};
    diff    = {q_sgn[33], q_sgn} - {{3{pos_cur[31]}}, pos_cur};
    if (diff[34:31] == 4'b0000 || diff[34:31] == 4'b1111) begin
      step_sat = diff[31:0];
    end else begin
      step_sat = diff[34] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    lim   = {1'b0, vmax_q[ax_q], 16'd0};
    n_cur = (ax_q[1] && res > {16'd0, lim}) ? lim : res[48:0];
    n_sel = (mode_q == lmsp_pkg::ModeRapid) ? lim : n_q[ax_q];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lmsp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = ok_now ? lmsp_pkg::ST_STEP : lmsp_pkg::ST_FINISH;
        end
      end
      lmsp_pkg::ST_STEP: begin
        if (adv && last_ax) begin
          state_d = (mode_q == lmsp_pkg::ModeRapid) ? lmsp_pkg::ST_RATE : lmsp_pkg::ST_SQR;
        end
      end
      lmsp_pkg::ST_SQR: begin
        if (adv && last_ax) state_d = lmsp_pkg::ST_ROOT;
      end
      lmsp_pkg::ST_ROOT: begin
        if (adv) state_d = lmsp_pkg::ST_COS;
      end
      lmsp_pkg::ST_COS: begin
        if (adv && last_ax) state_d = lmsp_pkg::ST_FEED;
      end
      lmsp_pkg::ST_FEED: begin
        if (adv && last_ax) state_d = lmsp_pkg::ST_RATE;
      end
      lmsp_pkg::ST_RATE: begin
        if (adv && last_ax) state_d = lmsp_pkg::ST_FINISH;
      end
      lmsp_pkg::ST_FINISH: begin
        if (out_free) state_d = lmsp_pkg::ST_IDLE;
      end
      default: state_d = lmsp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: requests and operands for the shared unit.
  always_comb begin
    req.start = 1'b0;
    req.op    = lmsp_pkg::OP_DIV;
    req.len   = lmsp_pkg::LenStepDiv;
    opx       = '0;
    opd       = '0;
    adv       = rsp.done;
    last_ax   = (ax_q == 2'd3);
    case (state_q)
      lmsp_pkg::ST_STEP: begin
        req.start = !issued_q;
        opx       = {abs_t, 32'd0};
        opd       = {32'd0, s_len};
      end
      lmsp_pkg::ST_SQR: begin
        req.start = !issued_q;
        req.op    = lmsp_pkg::OP_MUL;
        req.len   = lmsp_pkg::LenMul;
        opx       = {a_sh[ax_q][31:0], 32'd0};
        opd       = {32'd0, a_sh[ax_q][31:0]};
        last_ax   = (ax_q == 2'd2);
      end
      lmsp_pkg::ST_ROOT: begin
        req.start = !issued_q;
        req.op    = lmsp_pkg::OP_SQRT;
        req.len   = lmsp_pkg::LenSqrt;
        opx       = sum_q;
      end
      lmsp_pkg::ST_COS: begin
        req.start = !issued_q && (dist_q != 32'd0);
        req.len   = lmsp_pkg::LenWideDiv;
        opx       = {a_sh[ax_q], 31'd0};
        opd       = {32'd0, dist_q};
        adv       = rsp.done || (dist_q == 32'd0);
      end
      lmsp_pkg::ST_FEED: begin
        req.start = !issued_q;
        req.op    = lmsp_pkg::OP_MUL;
        req.len   = lmsp_pkg::LenMul;
        opx       = {feed_q, 32'd0};
        opd       = {15'd0, n_q[ax_q]};
      end
      lmsp_pkg::ST_RATE: begin
        req.start = !issued_q;
        req.len   = lmsp_pkg::LenWideDiv;
        opx       = {n_sel, 15'd0};
        opd       = {26'd0, div60};
      end
      default: begin
        adv = 1'b0;
      end
    endcase
  end

  lmsp_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opx_i  (opx),
    .opd_i  (opd),
    .rsp_o  (rsp),
    .res_o  (res)
  );

  // Result word, zero for a rejected move.
  always_comb begin
    out_data_d = '0;
    if (ok_q) begin
      out_data_d[3:0] = mask_q;
      for (int i = 0; i < lmsp_pkg::NumAxes; i++) begin
        out_data_d[4 + 32*i +: 32]   = dst_q[i];
        out_data_d[132 + 32*i +: 32] = rate_q[i];
      end
    end
  end

  // Control registers, configuration and positions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmsp_pkg::ST_IDLE;
      ax_q        <= '0;
      issued_q    <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_user_q  <= 1'b0;
      feed_q      <= '0;
      pos_mm_q    <= '0;
      pos_st_q    <= '0;
      step_len_q  <= {4{lmsp_pkg::StepLenReset}};
      vmax_q      <= {lmsp_pkg::ZeMaxReset, lmsp_pkg::ZeMaxReset,
                      lmsp_pkg::XyMaxReset, lmsp_pkg::XyMaxReset};
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          lmsp_pkg::CfgXStep: step_len_q[0] <= cfg_data_i;
          lmsp_pkg::CfgYStep: step_len_q[1] <= cfg_data_i;
          lmsp_pkg::CfgZStep: step_len_q[2] <= cfg_data_i;
          lmsp_pkg::CfgEStep: step_len_q[3] <= cfg_data_i;
          lmsp_pkg::CfgXMax:  vmax_q[0]     <= cfg_data_i;
          lmsp_pkg::CfgYMax:  vmax_q[1]     <= cfg_data_i;
          lmsp_pkg::CfgZMax:  vmax_q[2]     <= cfg_data_i;
          lmsp_pkg::CfgEMax:  vmax_q[3]     <= cfg_data_i;
          default: ;
        endcase
      end
      if (req.start) begin
        issued_q <= 1'b1;
      end else if (adv) begin
        issued_q <= 1'b0;
      end
      if (in_fire) begin
        ok_q <= ok_now;
        ax_q <= '0;
        if (s_axis_tdata_i[132]) feed_q <= s_axis_tdata_i[164:133];
      end else if (adv) begin
        ax_q <= (last_ax || state_q == lmsp_pkg::ST_ROOT) ? 2'd0 : ax_q + 2'd1;
      end
      if (m_axis_tready_i) out_valid_q <= 1'b0;
      if (state_q == lmsp_pkg::ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
        out_user_q  <= ok_q;
        if (ok_q) begin
          for (int i = 0; i < lmsp_pkg::NumAxes; i++) begin
            if (mask_q[i]) begin
              pos_mm_q[i] <= tgt_q[i];
              pos_st_q[i] <= pos_st_q[i] + dst_q[i];
            end
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= s_axis_tuser_i[1:0];
      mask_q <= s_axis_tdata_i[3:0];
      tgt_q  <= s_axis_tdata_i[131:4];
      sum_q  <= '0;
    end
    if (rsp.done) begin
      case (state_q)
        lmsp_pkg::ST_STEP: dst_q[ax_q]  <= mask_q[ax_q] ? step_sat : 32'd0;
        lmsp_pkg::ST_SQR:  sum_q        <= sum_q + res[63:0];
        lmsp_pkg::ST_ROOT: dist_q       <= res[31:0];
        lmsp_pkg::ST_COS:  n_q[ax_q]    <= res[48:0];
        lmsp_pkg::ST_FEED: n_q[ax_q]    <= n_cur;
        lmsp_pkg::ST_RATE: rate_q[ax_q] <= (res[64:32] != 33'd0) ? 32'hffff_ffff : res[31:0];
        default: ;
      endcase
    end
    // With a zero path length only the extruder moves, at the feed alone.
    if (state_q == lmsp_pkg::ST_COS && dist_q == 32'd0) begin
      n_q[ax_q] <= (ax_q == 2'd3) ? 49'd65536 : 49'd0;
    end
    if (state_q == lmsp_pkg::ST_FINISH && out_free) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !rsp.busy) else $error("shared unit started while busy");
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> issued_q) else $error("unit result without a request");
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lmsp_pkg::ST_FINISH) |=> $stable(pos_st_q) && $stable(pos_mm_q))
    else $error("positions changed outside the finish step");
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("rejected move carries nonzero data");
`endif

endmodule

`default_nettype wire
